### src/dual_servo_pwm_from_adc_top_macros.svh
// Assertion macros used by the port-level checker of the servo pulse block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef DUAL_SERVO_PWM_FROM_ADC_TOP_MACROS_SVH
`define DUAL_SERVO_PWM_FROM_ADC_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DSPWM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("servo pulse block: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DSPWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("servo pulse block: assertion failed");

`endif

### src/dspwm_pkg.sv
// Package for the dual servo pulse block: field widths, codes and the
// constants of the sample-to-width mapping. Depends on nothing.
package dspwm_pkg;

   // Field and register widths.
   localparam int WIDTH_W  = 11;
   localparam int PERIOD_W = 16;
   localparam int BAND_W   = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Request kinds and channel codes.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;
   localparam logic CHAN_A      = 1'b0;
   localparam logic CHAN_B      = 1'b1;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERIOD      = 3'd0,
      CSR_BAND_LOW_A  = 3'd1,
      CSR_BAND_HIGH_A = 3'd2,
      CSR_BAND_LOW_B  = 3'd3,
      CSR_BAND_HIGH_B = 3'd4
   } csr_index_type;

   // Reset values of the registers.
   localparam logic [PERIOD_W-1:0] PERIOD_RST      = 16'd20000;
   localparam logic [BAND_W-1:0]   BAND_LOW_A_RST  = 12'd1948;
   localparam logic [BAND_W-1:0]   BAND_HIGH_A_RST = 12'd2147;
   localparam logic [BAND_W-1:0]   BAND_LOW_B_RST  = 12'd1900;
   localparam logic [BAND_W-1:0]   BAND_HIGH_B_RST = 12'd2250;

   // Pulse widths in microseconds.
   localparam logic [WIDTH_W-1:0] WIDTH_MIN = 11'd1000;
   localparam logic [WIDTH_W-1:0] WIDTH_MID = 11'd1500;
   localparam logic [WIDTH_W-1:0] WIDTH_MAX = 11'd2000;

   // Scaling x*500/1947 is done as (x*SCALE_MUL) >> SCALE_SHIFT. The input is
   // saturated to 12 bits first; any larger value clamps the width anyway.
   // With a 23-bit shift the reciprocal error stays below one LSB of the
   // quotient for every 12-bit input, so the result is exact.
   localparam longint SCALE_NUM   = 500;
   localparam longint SCALE_DEN   = 1947;
   localparam int     SCALE_SHIFT = 23;
   localparam int     SCALE_IN_W  = 12;
   localparam int     SCALE_MUL_W = 22;
   localparam int     SCALE_PROD_W = SCALE_IN_W + SCALE_MUL_W;
   localparam int     SCALE_Q_W    = SCALE_PROD_W - SCALE_SHIFT;
   localparam logic [SCALE_IN_W-1:0]  SCALE_IN_MAX = '1;
   localparam logic [SCALE_MUL_W-1:0] SCALE_MUL =
      SCALE_MUL_W'((SCALE_NUM * (longint'(1) << SCALE_SHIFT) + SCALE_DEN - 1) / SCALE_DEN);

endpackage

### src/dual_servo_pwm_from_adc_top.sv
// Top level of the dual servo pulse generator: request register, mapping
// and frame logic, response register. Depends on dspwm_pkg.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_kind, req_channel, req_sample
//   rsp      out        rsp_valid/rsp_ready   rsp_level_a/b, rsp_width_a/b,
//                                             rsp_frame_start
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// One request per cycle while responses are taken. A taken request passes
// through the request register and then the response register, where it is
// offered until taken. A single pass of compare, subtract and one 12x22
// multiply sets the cycle.
// Synchronous reset restores the register defaults, zeroes the tick counter,
// sets both widths to 1500 and sets both drive levels low.
// A stalled response holds; a request is still taken while it can advance.
module dual_servo_pwm_from_adc_top #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic                                 req_channel,
   input  logic [SAMPLE_BITS-1:0]               req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_level_a,
   output logic                                 rsp_level_b,
   output logic [dspwm_pkg::WIDTH_W-1:0]        rsp_width_a,
   output logic [dspwm_pkg::WIDTH_W-1:0]        rsp_width_b,
   output logic                                 rsp_frame_start,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dspwm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dspwm_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int CmpW = (SAMPLE_BITS > dspwm_pkg::BAND_W) ? SAMPLE_BITS : dspwm_pkg::BAND_W;

   // Request register.
   logic                   in_valid_ff, in_valid_in;
   logic                   in_kind_ff;
   logic                   in_channel_ff;
   logic [SAMPLE_BITS-1:0] in_sample_ff;

   // Configuration registers.
   logic [dspwm_pkg::PERIOD_W-1:0] period_ff;
   logic [dspwm_pkg::BAND_W-1:0]   band_low_a_ff, band_high_a_ff;
   logic [dspwm_pkg::BAND_W-1:0]   band_low_b_ff, band_high_b_ff;

   // Generator state.
   logic [dspwm_pkg::PERIOD_W-1:0] tick_count_ff, tick_count_in;
   logic [dspwm_pkg::WIDTH_W-1:0]  pulse_width_a_ff, pulse_width_a_in;
   logic [dspwm_pkg::WIDTH_W-1:0]  pulse_width_b_ff, pulse_width_b_in;
   logic                           drive_a_ff, drive_a_in;
   logic                           drive_b_ff, drive_b_in;
   logic                           frame_in;

   // Response register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_level_a_ff, rsp_level_b_ff, rsp_frame_start_ff;
   logic [dspwm_pkg::WIDTH_W-1:0] rsp_width_a_ff, rsp_width_b_ff;

   // Mapping datapath.
   logic [CmpW-1:0]                        sample_ext, low_ext, high_ext, scale_src;
   logic                                   in_band, below_band;
   logic [dspwm_pkg::SCALE_IN_W-1:0]       scale_sat;
   logic [dspwm_pkg::SCALE_PROD_W-1:0]     scale_prod;
   logic [dspwm_pkg::SCALE_Q_W-1:0]        scale_q;
   logic [dspwm_pkg::WIDTH_W:0]            width_sum;
   logic [dspwm_pkg::WIDTH_W-1:0]          mapped_width;
   logic [dspwm_pkg::PERIOD_W-1:0]         tick_inc;
   logic                                   pipe_move;

   // Handshake: the request register empties into the response register
   // whenever that register is free or being read this cycle.
   assign pipe_move = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || pipe_move;
   assign csr_ready = 1'b1;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (pipe_move) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (pipe_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Sample to pulse width for the addressed channel.
   always_comb begin
      sample_ext = CmpW'(in_sample_ff);
      if (in_channel_ff == dspwm_pkg::CHAN_A) begin
         low_ext  = CmpW'(band_low_a_ff);
         high_ext = CmpW'(band_high_a_ff);
      end else begin
         low_ext  = CmpW'(band_low_b_ff);
         high_ext = CmpW'(band_high_b_ff);
      end
      below_band = sample_ext < low_ext;
      in_band    = !below_band && (sample_ext < high_ext);
      // Outside the band the sample is at or above both edges when not below.
      scale_src  = below_band ? sample_ext : (sample_ext - high_ext);
      if (scale_src > CmpW'(dspwm_pkg::SCALE_IN_MAX)) begin
         scale_sat = dspwm_pkg::SCALE_IN_MAX;
      end else begin
         scale_sat = scale_src[dspwm_pkg::SCALE_IN_W-1:0];
      end
      scale_prod = dspwm_pkg::SCALE_PROD_W'(scale_sat)
                   * dspwm_pkg::SCALE_PROD_W'(dspwm_pkg::SCALE_MUL);
      scale_q    = scale_prod[dspwm_pkg::SCALE_PROD_W-1:dspwm_pkg::SCALE_SHIFT];
      if (below_band) begin
         width_sum = {1'b0, dspwm_pkg::WIDTH_MIN} + (dspwm_pkg::WIDTH_W+1)'(scale_q);
      end else begin
         width_sum = {1'b0, dspwm_pkg::WIDTH_MID} + (dspwm_pkg::WIDTH_W+1)'(scale_q);
      end
      if (in_band) begin
         mapped_width = dspwm_pkg::WIDTH_MID;
      end else if (width_sum > {1'b0, dspwm_pkg::WIDTH_MAX}) begin
         mapped_width = dspwm_pkg::WIDTH_MAX;
      end else begin
         mapped_width = width_sum[dspwm_pkg::WIDTH_W-1:0];
      end
   end

   // Next state of the frame counter, widths and drive levels.
   always_comb begin
      tick_inc         = tick_count_ff + 16'd1;
      tick_count_in    = tick_count_ff;
      pulse_width_a_in = pulse_width_a_ff;
      pulse_width_b_in = pulse_width_b_ff;
      drive_a_in       = drive_a_ff;
      drive_b_in       = drive_b_ff;
      frame_in         = 1'b0;
      if (in_kind_ff == dspwm_pkg::KIND_SAMPLE) begin
         if (in_channel_ff == dspwm_pkg::CHAN_A) begin
            pulse_width_a_in = mapped_width;
         end else begin
            pulse_width_b_in = mapped_width;
         end
      end else if (tick_inc >= period_ff) begin
         tick_count_in = '0;
         drive_a_in    = 1'b1;
         drive_b_in    = 1'b1;
         frame_in      = 1'b1;
      end else begin
         tick_count_in = tick_inc;
         if (tick_inc == dspwm_pkg::PERIOD_W'(pulse_width_a_ff)) begin
            drive_a_in = 1'b0;
         end
         if (tick_inc == dspwm_pkg::PERIOD_W'(pulse_width_b_ff)) begin
            drive_b_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         period_ff        <= dspwm_pkg::PERIOD_RST;
         band_low_a_ff    <= dspwm_pkg::BAND_LOW_A_RST;
         band_high_a_ff   <= dspwm_pkg::BAND_HIGH_A_RST;
         band_low_b_ff    <= dspwm_pkg::BAND_LOW_B_RST;
         band_high_b_ff   <= dspwm_pkg::BAND_HIGH_B_RST;
         tick_count_ff    <= '0;
         pulse_width_a_ff <= dspwm_pkg::WIDTH_MID;
         pulse_width_b_ff <= dspwm_pkg::WIDTH_MID;
         drive_a_ff       <= 1'b0;
         drive_b_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // Register writes; indexes beyond the list are dropped.
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               dspwm_pkg::CSR_PERIOD:      period_ff      <= csr_data;
               dspwm_pkg::CSR_BAND_LOW_A:  band_low_a_ff  <= csr_data[dspwm_pkg::BAND_W-1:0];
               dspwm_pkg::CSR_BAND_HIGH_A: band_high_a_ff <= csr_data[dspwm_pkg::BAND_W-1:0];
               dspwm_pkg::CSR_BAND_LOW_B:  band_low_b_ff  <= csr_data[dspwm_pkg::BAND_W-1:0];
               dspwm_pkg::CSR_BAND_HIGH_B: band_high_b_ff <= csr_data[dspwm_pkg::BAND_W-1:0];
               default: ;
            endcase
         end
         if (pipe_move) begin
            tick_count_ff    <= tick_count_in;
            pulse_width_a_ff <= pulse_width_a_in;
            pulse_width_b_ff <= pulse_width_b_in;
            drive_a_ff       <= drive_a_in;
            drive_b_ff       <= drive_b_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff    <= req_kind;
         in_channel_ff <= req_channel;
         in_sample_ff  <= req_sample;
      end
      if (pipe_move) begin
         rsp_level_a_ff     <= drive_a_in;
         rsp_level_b_ff     <= drive_b_in;
         rsp_width_a_ff     <= pulse_width_a_in;
         rsp_width_b_ff     <= pulse_width_b_in;
         rsp_frame_start_ff <= frame_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_level_a     = rsp_level_a_ff;
   assign rsp_level_b     = rsp_level_b_ff;
   assign rsp_width_a     = rsp_width_a_ff;
   assign rsp_width_b     = rsp_width_b_ff;
   assign rsp_frame_start = rsp_frame_start_ff;

endmodule

### src/dspwm_checker.sv
// Port-level checker for the dual servo pulse block and its bind statement.
// Depends on dspwm_pkg and dual_servo_pwm_from_adc_top_macros.svh.
`include "dual_servo_pwm_from_adc_top_macros.svh"

module dspwm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_level_a,
   input logic                            rsp_level_b,
   input logic [dspwm_pkg::WIDTH_W-1:0]   rsp_width_a,
   input logic [dspwm_pkg::WIDTH_W-1:0]   rsp_width_b,
   input logic                            rsp_frame_start
);

   // A stalled response keeps its valid and its payload.
   `DSPWM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_level_a) && $stable(rsp_level_b)
      && $stable(rsp_width_a) && $stable(rsp_width_b) && $stable(rsp_frame_start))

   // A frame start always comes with both outputs driven high.
   `DSPWM_ASSERT_IMPLY(a_frame_levels, clock, reset, rsp_valid && rsp_frame_start,
      rsp_level_a && rsp_level_b)

   // Every accepted request is followed by a response on offer at the response register.
   `DSPWM_ASSERT_IMPLY(a_req_latency, clock, reset, req_valid && req_ready, ##2 rsp_valid)

endmodule

bind dual_servo_pwm_from_adc_top dspwm_checker u_dspwm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_level_a     (rsp_level_a),
   .rsp_level_b     (rsp_level_b),
   .rsp_width_a     (rsp_width_a),
   .rsp_width_b     (rsp_width_b),
   .rsp_frame_start (rsp_frame_start)
);

### tb/servo_pwm_checker.sv
// Response checker for the dual servo pulse block: it follows the request,
// register and response channels and compares every response with its own
// prediction. Depends on dspwm_pkg.
module servo_pwm_checker #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_kind,
   input  logic                               req_channel,
   input  logic [SAMPLE_BITS-1:0]             req_sample,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_level_a,
   input  logic                               rsp_level_b,
   input  logic [dspwm_pkg::WIDTH_W-1:0]      rsp_width_a,
   input  logic [dspwm_pkg::WIDTH_W-1:0]      rsp_width_b,
   input  logic                               rsp_frame_start,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [dspwm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dspwm_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                                 failures,
   output int                                 outstanding
);

   localparam int REPORT_LIMIT = 10;
   localparam int WIDTH_W      = dspwm_pkg::WIDTH_W;
   localparam int PERIOD_W     = dspwm_pkg::PERIOD_W;
   localparam int BAND_W       = dspwm_pkg::BAND_W;

   // One response as the block presents it.
   typedef struct packed {
      logic               level_a;
      logic               level_b;
      logic [WIDTH_W-1:0] width_a;
      logic [WIDTH_W-1:0] width_b;
      logic               frame_start;
   } servo_outputs_type;

   // Register copies, indexed by channel code.
   logic [PERIOD_W-1:0] frame_len;
   logic [BAND_W-1:0]   band_floor [2];
   logic [BAND_W-1:0]   band_ceil [2];

   // Block state as this checker sees it.
   logic [PERIOD_W-1:0] us_count;
   logic [WIDTH_W-1:0]  pulse_len [2];
   logic                drive [2];

   servo_outputs_type outputs_due [$];
   int                responses_seen;

   // Converter reading to pulse width, including the dead band and the clamp.
   function automatic logic [WIDTH_W-1:0] sample_to_width(
      input logic [SAMPLE_BITS-1:0] s,
      input logic [BAND_W-1:0]      lo,
      input logic [BAND_W-1:0]      hi
   );
      longint w;
      if (s >= lo && s < hi) begin
         w = dspwm_pkg::WIDTH_MID;
      end else if (s < lo) begin
         w = dspwm_pkg::WIDTH_MIN
             + (longint'(s) * dspwm_pkg::SCALE_NUM) / dspwm_pkg::SCALE_DEN;
      end else begin
         // Here the sample is at or above both edges.
         w = dspwm_pkg::WIDTH_MID
             + (longint'(s - hi) * dspwm_pkg::SCALE_NUM) / dspwm_pkg::SCALE_DEN;
      end
      if (w < dspwm_pkg::WIDTH_MIN) w = dspwm_pkg::WIDTH_MIN;
      if (w > dspwm_pkg::WIDTH_MAX) w = dspwm_pkg::WIDTH_MAX;
      return WIDTH_W'(w);
   endfunction

   task automatic flag(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("servo check: %s", msg);
   endtask

   // Responses are taken before new requests: a response leaving at this edge
   // always belongs to a request taken at an earlier edge.
   always @(posedge clock) begin : predict_and_compare
      servo_outputs_type got;
      servo_outputs_type due;
      logic              frame;
      if (reset) begin
         frame_len      = dspwm_pkg::PERIOD_RST;
         band_floor[0]  = dspwm_pkg::BAND_LOW_A_RST;
         band_ceil[0]   = dspwm_pkg::BAND_HIGH_A_RST;
         band_floor[1]  = dspwm_pkg::BAND_LOW_B_RST;
         band_ceil[1]   = dspwm_pkg::BAND_HIGH_B_RST;
         us_count       = '0;
         pulse_len[0]   = dspwm_pkg::WIDTH_MID;
         pulse_len[1]   = dspwm_pkg::WIDTH_MID;
         drive[0]       = 1'b0;
         drive[1]       = 1'b0;
         failures       = 0;
         responses_seen = 0;
         outputs_due.delete();
      end else begin
         // Compare a leaving response with the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_level_a, rsp_level_b, rsp_width_a, rsp_width_b, rsp_frame_start};
            if (outputs_due.size() == 0) begin
               flag($sformatf({"response %0d arrived with no request pending:",
                  " la=%b lb=%b wa=%0d wb=%0d fs=%b"}, responses_seen, got.level_a,
                  got.level_b, got.width_a, got.width_b, got.frame_start));
            end else begin
               due = outputs_due.pop_front();
               if (got !== due) begin
                  flag($sformatf({"response %0d: expected la=%b lb=%b wa=%0d wb=%0d fs=%b,",
                     " got la=%b lb=%b wa=%0d wb=%0d fs=%b"}, responses_seen,
                     due.level_a, due.level_b, due.width_a, due.width_b, due.frame_start,
                     got.level_a, got.level_b, got.width_a, got.width_b, got.frame_start));
               end
            end
            responses_seen++;
         end

         // Register writes; indexes past the last register are dropped.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dspwm_pkg::CSR_PERIOD:      frame_len     = csr_data[PERIOD_W-1:0];
               dspwm_pkg::CSR_BAND_LOW_A:  band_floor[0] = csr_data[BAND_W-1:0];
               dspwm_pkg::CSR_BAND_HIGH_A: band_ceil[0]  = csr_data[BAND_W-1:0];
               dspwm_pkg::CSR_BAND_LOW_B:  band_floor[1] = csr_data[BAND_W-1:0];
               dspwm_pkg::CSR_BAND_HIGH_B: band_ceil[1]  = csr_data[BAND_W-1:0];
               default: ;
            endcase
         end

         // A sample sets its channel's width; a tick advances the frame.
         if (req_valid && req_ready) begin
            frame = 1'b0;
            if (req_kind == dspwm_pkg::KIND_SAMPLE) begin
               pulse_len[req_channel] = sample_to_width(req_sample, band_floor[req_channel],
                  band_ceil[req_channel]);
            end else begin
               us_count = us_count + 1'b1;
               if (us_count >= frame_len) begin
                  us_count = '0;
                  drive[0] = 1'b1;
                  drive[1] = 1'b1;
                  frame    = 1'b1;
               end else begin
                  for (int ch = 0; ch < 2; ch++) begin
                     if (us_count == PERIOD_W'(pulse_len[ch])) drive[ch] = 1'b0;
                  end
               end
            end
            outputs_due.push_back('{drive[dspwm_pkg::CHAN_A], drive[dspwm_pkg::CHAN_B],
               pulse_len[dspwm_pkg::CHAN_A], pulse_len[dspwm_pkg::CHAN_B], frame});
         end
      end
      outstanding = outputs_due.size();
   end

endmodule

### tb/dual_servo_pwm_from_adc_top_tb.sv
// Testbench top for the dual servo pulse block: clock, reset, request and
// register stimulus, response stalls and the verdict. Depends on dspwm_pkg,
// dual_servo_pwm_from_adc_top and servo_pwm_checker.
module dual_servo_pwm_from_adc_top_tb;

   localparam int SAMPLE_BITS = 12;
   localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
   localparam int GAP_MAX     = 12;
   localparam int RUN_LIMIT   = 1000000;
   localparam int WIDTH_W     = dspwm_pkg::WIDTH_W;
   localparam int PERIOD_W    = dspwm_pkg::PERIOD_W;
   localparam int BAND_W      = dspwm_pkg::BAND_W;
   localparam int CSR_IDX_W   = dspwm_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = dspwm_pkg::CSR_DATA_W;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid   = 1'b0;
   logic                   req_kind    = dspwm_pkg::KIND_TICK;
   logic                   req_channel = dspwm_pkg::CHAN_A;
   logic [SAMPLE_BITS-1:0] req_sample  = '0;
   logic                   req_ready;

   logic                   rsp_ready = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_level_a;
   logic                   rsp_level_b;
   logic [WIDTH_W-1:0]     rsp_width_a;
   logic [WIDTH_W-1:0]     rsp_width_b;
   logic                   rsp_frame_start;

   logic                   csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = dspwm_pkg::CSR_PERIOD;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;
   logic                   csr_ready;

   int failures;
   int outstanding;

   // Idling is switched off for some phases to get back-to-back traffic.
   logic idle_on = 1'b1;

   // Band edges last written, used to aim samples at the edges.
   logic [BAND_W-1:0] band_lo_now [2] =
      '{dspwm_pkg::BAND_LOW_A_RST, dspwm_pkg::BAND_LOW_B_RST};
   logic [BAND_W-1:0] band_hi_now [2] =
      '{dspwm_pkg::BAND_HIGH_A_RST, dspwm_pkg::BAND_HIGH_B_RST};

   dual_servo_pwm_from_adc_top #(.SAMPLE_BITS(SAMPLE_BITS)) dut (.*);

   servo_pwm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) pulse_check (.*);

   always #1 clock = ~clock;

   function automatic int draw_gap();
      if (!idle_on || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, GAP_MAX);
   endfunction

   // Response side: stall a random number of cycles before each response.
   always begin : rsp_stall
      int hold;
      hold = draw_gap();
      if (hold > 0) begin
         rsp_ready <= 1'b0;
         repeat (hold) @(posedge clock);
      end
      rsp_ready <= 1'b1;
      do @(posedge clock); while (!rsp_valid);
   end

   // Offer one request after a random gap and wait until it is taken.
   task automatic send_request(input logic kind, input logic chan,
                               input logic [SAMPLE_BITS-1:0] value);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_channel <= chan;
      req_sample  <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes every register, band values with random upper bits, and then one
   // index past the last register, which the block must drop.
   task automatic configure(input logic [PERIOD_W-1:0] period,
                            input logic [BAND_W-1:0] lo_a, input logic [BAND_W-1:0] hi_a,
                            input logic [BAND_W-1:0] lo_b, input logic [BAND_W-1:0] hi_b);
      localparam int PAD_W = CSR_DATA_W - BAND_W;
      write_reg(dspwm_pkg::CSR_PERIOD, period);
      write_reg(dspwm_pkg::CSR_BAND_LOW_A, {PAD_W'($urandom), lo_a});
      write_reg(dspwm_pkg::CSR_BAND_HIGH_A, {PAD_W'($urandom), hi_a});
      write_reg(dspwm_pkg::CSR_BAND_LOW_B, {PAD_W'($urandom), lo_b});
      write_reg(dspwm_pkg::CSR_BAND_HIGH_B, {PAD_W'($urandom), hi_b});
      write_reg(CSR_IDX_W'(dspwm_pkg::CSR_BAND_HIGH_B) + CSR_IDX_W'($urandom_range(1, 3)),
                CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      band_lo_now[0] = lo_a;
      band_hi_now[0] = hi_a;
      band_lo_now[1] = lo_b;
      band_hi_now[1] = hi_b;
   endtask

   // Lower valid, wait for every predicted response, resume at a rising edge.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   // Small readings give widths near 1000; others sit near the band edges or
   // anywhere in the range.
   function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic chan, input int low_pct);
      int roll;
      int near;
      roll = $urandom_range(0, 99);
      if (roll < low_pct) return SAMPLE_BITS'($urandom_range(0, 500));
      if (roll < low_pct + 15) begin
         near = $urandom_range(0, 1) ? int'(band_lo_now[chan]) : int'(band_hi_now[chan]);
         near = near + int'($urandom_range(0, 2)) - 1;
         if (near < 0) near = 0;
         if (near > SAMPLE_MAX) near = SAMPLE_MAX;
         return SAMPLE_BITS'(near);
      end
      return SAMPLE_BITS'($urandom);
   endfunction

   task automatic run_random(input int count, input int tick_pct, input int low_pct);
      logic chan;
      repeat (count) begin
         chan = 1'($urandom);
         if ($urandom_range(0, 99) < tick_pct) begin
            send_request(dspwm_pkg::KIND_TICK, chan, SAMPLE_BITS'($urandom));
         end else begin
            send_request(dspwm_pkg::KIND_SAMPLE, chan, pick_sample(chan, low_pct));
         end
      end
   endtask

   // Run limit.
   initial begin : watchdog
      #(RUN_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      logic [BAND_W-1:0]      lo_a, hi_a, lo_b, hi_b;
      logic [SAMPLE_BITS-1:0] full_scale;

      full_scale = SAMPLE_BITS'(SAMPLE_MAX);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: full-scale ends and both sides of every band edge.
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_A, '0);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_A, full_scale);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_A, dspwm_pkg::BAND_LOW_A_RST - 1'b1);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_A, dspwm_pkg::BAND_LOW_A_RST);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_A, dspwm_pkg::BAND_HIGH_A_RST - 1'b1);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_A, dspwm_pkg::BAND_HIGH_A_RST);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_B, dspwm_pkg::BAND_LOW_B_RST - 1'b1);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_B, dspwm_pkg::BAND_LOW_B_RST);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_B, dspwm_pkg::BAND_HIGH_B_RST - 1'b1);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_B, dspwm_pkg::BAND_HIGH_B_RST);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_B, full_scale);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_B, '0);
      send_request(dspwm_pkg::KIND_TICK, dspwm_pkg::CHAN_A, full_scale);
      send_request(dspwm_pkg::KIND_TICK, dspwm_pkg::CHAN_B, '0);
      wait_drained();

      // One-tick frame, a reversed band on A and the widest band on B.
      configure(16'd1, 12'd3000, 12'd1000, '0, BAND_W'(SAMPLE_MAX));
      send_request(dspwm_pkg::KIND_TICK, dspwm_pkg::CHAN_A, '0);
      send_request(dspwm_pkg::KIND_TICK, dspwm_pkg::CHAN_B, '0);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_A, 12'd2999);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_A, 12'd3000);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_A, 12'd1500);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_B, full_scale - 1'b1);
      send_request(dspwm_pkg::KIND_SAMPLE, dspwm_pkg::CHAN_B, full_scale);
      send_request(dspwm_pkg::KIND_TICK, dspwm_pkg::CHAN_A, '0);
      wait_drained();

      // Zero-length frame: every tick ends a frame.
      configure('0, 12'd3000, 12'd1000, '0, BAND_W'(SAMPLE_MAX));
      send_request(dspwm_pkg::KIND_TICK, dspwm_pkg::CHAN_A, '0);
      send_request(dspwm_pkg::KIND_TICK, dspwm_pkg::CHAN_B, '0);
      wait_drained();

      // Shortest legal frame; widths are never reached.
      lo_a = BAND_W'($urandom_range(0, 2047));
      hi_a = lo_a + BAND_W'($urandom_range(0, 2048));
      lo_b = BAND_W'($urandom_range(0, 2047));
      hi_b = lo_b + BAND_W'($urandom_range(0, 2048));
      configure(16'd2, lo_a, hi_a, lo_b, hi_b);
      run_random(150, 50, 20);
      wait_drained();

      // Longest frame with empty bands at both ends of the range, no idling.
      idle_on = 1'b0;
      configure('1, '0, '0, BAND_W'(SAMPLE_MAX), BAND_W'(SAMPLE_MAX));
      run_random(150, 30, 20);
      wait_drained();

      // Frames just longer than the narrowest pulses, mostly ticks, so both
      // outputs fall at their widths and rise again at the frame end.
      idle_on = 1'b1;
      lo_a = BAND_W'($urandom_range(1800, 2000));
      hi_a = lo_a + BAND_W'($urandom_range(0, 300));
      lo_b = BAND_W'($urandom_range(1800, 2000));
      hi_b = lo_b + BAND_W'($urandom_range(0, 300));
      configure(PERIOD_W'($urandom_range(1050, 1250)), lo_a, hi_a, lo_b, hi_b);
      run_random(1300, 93, 70);
      wait_drained();

      // Reversed bands with frames shorter than any width.
      hi_a = BAND_W'($urandom_range(0, 2047));
      lo_a = hi_a + BAND_W'($urandom_range(1, 2048));
      hi_b = BAND_W'($urandom_range(0, 2047));
      lo_b = hi_b + BAND_W'($urandom_range(1, 2048));
      configure(PERIOD_W'($urandom_range(2, 40)), lo_a, hi_a, lo_b, hi_b);
      run_random(150, 50, 30);
      wait_drained();

      // Frame length below two with random bands.
      lo_a = BAND_W'($urandom);
      hi_a = BAND_W'($urandom);
      lo_b = BAND_W'($urandom);
      hi_b = BAND_W'($urandom);
      configure(PERIOD_W'($urandom_range(0, 1)), lo_a, hi_a, lo_b, hi_b);
      run_random(150, 50, 20);
      wait_drained();

      // Catch any stray response after the last expected one.
      repeat (4) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
